### design/emi_pkg.sv
package emi_pkg;

  typedef struct packed {
    logic               mode;
    logic [7:0]         entity;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [15:0]        weight;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
  } emi_in_t;

  typedef struct packed {
    logic [7:0]         entity_out;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               grounded;
    logic               zero_weight;
  } emi_out_t;

  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_LOAD = 1'b1;
  localparam int   DIV_STEPS = 32;

endpackage

### design/entity_motion_integrator_core.sv
// Entity motion integrator.
// Input channel: drive item with start high; the item is taken at an edge
// where start is high and busy is low. Mode step integrates one entity:
// position += trunc(velocity), accel = force / weight, velocity += floor of
// the mean of new and last accel, then ground clamp on z. Mode load writes
// position and velocity and clears last acceleration.
// Output channel: result is on result for one cycle with done high; there
// is no back pressure.
// Sequence: a step item goes from the accepting edge to a read state, the
// divide in three parallel per-axis lanes and an update and merge state,
// which registers the result on the ports; a load item skips the divide.
// One item is in flight at a time: the next item is taken only once the
// core is back in idle, after the output state that follows the update.
// Reset: rst runs a clearing pass over all 3*ENTITY_COUNT words, one entity
// per cycle, with busy high throughout.
module entity_motion_integrator_core #(
  parameter int ENTITY_COUNT = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  emi_pkg::emi_in_t item,
  output logic             busy,
  output logic             done,
  output emi_pkg::emi_out_t result
);
  import emi_pkg::*;

  localparam int AW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
  localparam int CW = $clog2(DIV_STEPS + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_READ = 6'b000100,
    S_DIV   = 6'b001000, S_UPD  = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [AW:0] clr;
  logic [CW-1:0] cnt;
  emi_in_t req;
  logic [AW-1:0] addr;

  logic [95:0] pos_mem [ENTITY_COUNT];
  logic [95:0] vel_mem [ENTITY_COUNT];
  logic [95:0] acc_mem [ENTITY_COUNT];
  logic [95:0] pos_rd, vel_rd, acc_rd;
  logic [95:0] pos_wr, vel_wr, acc_wr;
  logic        we;
  logic [AW-1:0] waddr;

  logic signed [31:0] quo [3];
  logic signed [31:0] acc [3];
  logic signed [31:0] pn [3];
  logic signed [31:0] vn [3];
  logic step, zw;
  logic signed [FRAC_BITS+33:0] zs;
  logic gnd;

  assign step = (req.mode == MODE_STEP);
  assign zw   = (req.weight == 16'd0);
  assign addr = AW'(32'(item.entity) % ENTITY_COUNT);

  for (genvar a = 0; a < 3; a++) begin : g_lane
    emi_div_lane u_div (
      .clk(clk), .start(state == S_READ),
      .dividend(a == 0 ? req.force_x : (a == 1 ? req.force_y : req.force_z)),
      .divisor(req.weight), .quotient(quo[a])
    );
    assign acc[a] = (step && !zw) ? quo[a] : 32'sd0;
    emi_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_axis (
      .step(step), .pos(pos_rd[a*32 +: 32]), .vel(vel_rd[a*32 +: 32]),
      .last(acc_rd[a*32 +: 32]), .acc(acc[a]), .pos_next(pn[a]), .vel_next(vn[a])
    );
  end

  // Merge: ground clamp on z across the lanes' results.
  always_comb begin
    zs  = ((FRAC_BITS+34)'(pn[2]) <<< FRAC_BITS) + (FRAC_BITS+34)'(vn[2]);
    gnd = step && (pn[2][31] || zs[FRAC_BITS+33] || zs == '0);
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(32'(req.entity) % ENTITY_COUNT);
    pos_wr = {pn[2], pn[1], pn[0]};
    vel_wr = {vn[2], vn[1], vn[0]};
    acc_wr = {acc[2], acc[1], acc[0]};
    if (gnd) begin
      pos_wr[95:64] = '0;
      vel_wr[95:64] = '0;
    end
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr[AW-1:0];
      pos_wr = '0; vel_wr = '0; acc_wr = '0;
    end else if (state == S_UPD) begin
      we = 1'b1;
      if (!step) begin
        pos_wr = {req.load_pos_z, req.load_pos_y, req.load_pos_x};
        vel_wr = {req.load_vel_z, req.load_vel_y, req.load_vel_x};
        acc_wr = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= pos_wr;
      vel_mem[waddr] <= vel_wr;
      acc_mem[waddr] <= acc_wr;
    end
    if (state == S_IDLE) begin
      pos_rd <= pos_mem[addr];
      vel_rd <= vel_mem[addr];
      acc_rd <= acc_mem[addr];
    end
    if (state == S_UPD) begin
      result.entity_out  <= req.entity;
      result.new_pos_x   <= pos_wr[31:0];
      result.new_pos_y   <= pos_wr[63:32];
      result.new_pos_z   <= pos_wr[95:64];
      result.new_vel_x   <= vel_wr[31:0];
      result.new_vel_y   <= vel_wr[63:32];
      result.new_vel_z   <= vel_wr[95:64];
      result.grounded    <= gnd;
      result.zero_weight <= step && zw;
    end
    if (state == S_IDLE && start) req <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(ENTITY_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) state <= S_READ;
        S_READ: begin
          cnt   <= '0;
          state <= step ? S_DIV : S_UPD;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DIV_STEPS - 1)) state <= S_UPD;
        end
        S_UPD: begin
          state <= S_OUT;
          done  <= 1'b1;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
endmodule

### design/emi_div_lane.sv
module emi_div_lane (
  input  logic               clk,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [15:0]        divisor,
  output logic signed [31:0] quotient
);
  import emi_pkg::*;

  // Restoring divide on magnitudes, one quotient bit per cycle.
  logic [31:0] q;
  logic [16:0] rem;
  logic        neg;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial = {rem[15:0], q[31]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[31] ? 32'(-dividend) : dividend;
      rem <= '0;
      neg <= dividend[31];
      dvs <= divisor;
    end else if (!diff[16]) begin
      rem <= diff;
      q   <= {q[30:0], 1'b1};
    end else begin
      rem <= trial;
      q   <= {q[30:0], 1'b0};
    end
  end

  assign quotient = neg ? 32'(-q) : q;
endmodule

### design/emi_axis_lane.sv
module emi_axis_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               step,
  input  logic signed [31:0] pos,
  input  logic signed [31:0] vel,
  input  logic signed [31:0] last,
  input  logic signed [31:0] acc,
  output logic signed [31:0] pos_next,
  output logic signed [31:0] vel_next
);
  import emi_pkg::*;

  logic [31:0] mag;
  logic signed [31:0] vint;
  logic signed [32:0] sum;

  always_comb begin
    mag  = vel[31] ? 32'(-vel) : vel;
    mag  = mag >> FRAC_BITS;
    vint = vel[31] ? 32'(-mag) : mag;
    sum  = 33'(acc) + 33'(last);
    pos_next = step ? 32'(pos + vint) : pos;
    vel_next = step ? 32'(vel + 32'(sum >>> 1)) : vel;
  end
endmodule

### tb/tb_entity_motion_integrator_checker.sv
module tb_entity_motion_integrator_checker #(
  parameter int ENTITY_COUNT = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  emi_pkg::emi_in_t  item,
  input  logic              done,
  input  emi_pkg::emi_out_t result,
  output int                fail_count,
  output int                pending_count,
  output int                result_count,
  output int                grounded_count,
  output int                zero_weight_count
);
  import emi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] pos_mem [3*ENTITY_COUNT];
  logic signed [31:0] vel_mem [3*ENTITY_COUNT];
  logic signed [31:0] accel_mem [3*ENTITY_COUNT];
  emi_out_t motion_q[$];

  function automatic logic signed [31:0] vel_to_int(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    if (w >= 0) return 32'(w >>> FRAC_BITS);
    return 32'(-((-w) >>> FRAC_BITS));
  endfunction

  task automatic integrate(input emi_in_t it);
    emi_out_t r;
    int base;
    logic signed [31:0] f [3];
    logic signed [31:0] p, v, acc;
    logic signed [32:0] sum;
    logic signed [63:0] lift;
    base = (int'(it.entity) % ENTITY_COUNT) * 3;
    f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
    r = '0;
    r.entity_out = it.entity;
    if (it.mode == MODE_LOAD) begin
      pos_mem[base] = it.load_pos_x; pos_mem[base+1] = it.load_pos_y;
      pos_mem[base+2] = it.load_pos_z;
      vel_mem[base] = it.load_vel_x; vel_mem[base+1] = it.load_vel_y;
      vel_mem[base+2] = it.load_vel_z;
      for (int a = 0; a < 3; a++) accel_mem[base+a] = '0;
    end else begin
      r.zero_weight = (it.weight == 0);
      for (int a = 0; a < 3; a++) begin
        p = pos_mem[base+a];
        v = vel_mem[base+a];
        acc = r.zero_weight ? 32'sd0 :
              32'(64'(f[a]) / $signed({48'd0, it.weight}));
        p = p + vel_to_int(v);
        sum = 33'(acc) + 33'(accel_mem[base+a]);
        v = v + 32'(sum >>> 1);
        pos_mem[base+a] = p;
        vel_mem[base+a] = v;
        accel_mem[base+a] = acc;
      end
      // ground clamp on z, compared at full precision
      lift = (64'(pos_mem[base+2]) <<< FRAC_BITS) + 64'(vel_mem[base+2]);
      if (pos_mem[base+2] < 0 || lift <= 0) begin
        pos_mem[base+2] = '0;
        vel_mem[base+2] = '0;
        r.grounded = 1'b1;
      end
    end
    r.new_pos_x = pos_mem[base]; r.new_pos_y = pos_mem[base+1];
    r.new_pos_z = pos_mem[base+2];
    r.new_vel_x = vel_mem[base]; r.new_vel_y = vel_mem[base+1];
    r.new_vel_z = vel_mem[base+2];
    motion_q.push_back(r);
  endtask

  initial begin
    for (int i = 0; i < 3*ENTITY_COUNT; i++) begin
      pos_mem[i] = '0; vel_mem[i] = '0; accel_mem[i] = '0;
    end
    fail_count = 0; result_count = 0; grounded_count = 0; zero_weight_count = 0;
  end

  assign pending_count = motion_q.size();

  always @(posedge clk) begin
    emi_out_t want;
    if (!rst && done) begin
      result_count++;
      if (motion_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %p", result);
      end else begin
        want = motion_q.pop_front();
        if (want.grounded) grounded_count++;
        if (want.zero_weight) zero_weight_count++;
        if (result !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch entity %0d\n  expected %p\n  actual   %p",
                     want.entity_out, want, result);
        end
      end
    end
    if (!rst && start && !busy) integrate(item);
  end
endmodule

### tb/tb_entity_motion_integrator_core.sv
module tb_entity_motion_integrator_core;
  import emi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  emi_in_t item = '0;
  logic busy, done;
  emi_out_t result;
  int fail_count, pending_count, result_count, grounded_count, zero_weight_count;
  int sent = 0;

  always #2 clk = ~clk;

  entity_motion_integrator_core uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  tb_entity_motion_integrator_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count),
    .grounded_count(grounded_count), .zero_weight_count(zero_weight_count)
  );

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return 32'($signed($urandom_range(0, 2000)) - 1000);
      5: return 32'($signed($urandom_range(0, 400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hffff;
      2: return 16'd1;
      3: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  // send one item, at random with an idle burst ahead of it early in the run;
  // start stays high between back-to-back items
  task automatic send(input emi_in_t it, input bit may_idle);
    if (may_idle && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic emi_in_t load_item(logic [7:0] ent, logic [31:0] px, py, pz,
                                        logic [31:0] vx, vy, vz);
    emi_in_t it;
    it = '0;
    it.mode = MODE_LOAD; it.entity = ent;
    it.load_pos_x = px; it.load_pos_y = py; it.load_pos_z = pz;
    it.load_vel_x = vx; it.load_vel_y = vy; it.load_vel_z = vz;
    it.force_x = $urandom; it.weight = 16'($urandom);
    return it;
  endfunction

  function automatic emi_in_t step_item(logic [7:0] ent, logic [31:0] fx, fy, fz,
                                        logic [15:0] w);
    emi_in_t it;
    it = '0;
    it.mode = MODE_STEP; it.entity = ent;
    it.force_x = fx; it.force_y = fy; it.force_z = fz; it.weight = w;
    it.load_pos_x = $urandom; it.load_vel_z = $urandom;
    return it;
  endfunction

  initial begin
    emi_in_t it;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, zero weight, wrap, ground clamp on both conditions
    send(step_item(8'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'd1), 1);
    send(step_item(8'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 16'd0), 1);
    send(load_item(8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'd10,
                   32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000), 1);
    send(step_item(8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd1), 1);
    send(step_item(8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff), 1);
    send(load_item(8'd7, 32'd5, 32'hffff_fffb, 32'hffff_ffff, 32'hffff_8000,
                   32'h0000_8000, 32'd0), 1);
    send(step_item(8'd7, 32'd3, 32'hffff_fffd, 32'd0, 16'd2), 1);
    send(load_item(8'd8, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'hffff_0000), 1);
    send(step_item(8'd8, 32'd0, 32'd0, 32'd0, 16'd3), 1);
    send(load_item(8'd9, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'hffff_0001), 1);
    send(step_item(8'd9, 32'd0, 32'd0, 32'd0, 16'd5), 1);
    send(step_item(8'd128, 32'hffff_ffff, 32'd1, 32'd0, 16'hffff), 1);
    send(load_item(8'd100, 32'd0, 32'd0, 32'd1000, 32'hfffe_0001, 32'h0001_ffff,
                   32'h0010_0000), 1);
    for (int i = 0; i < 6; i++)
      send(step_item(8'd100, pick_word(), pick_word(), 32'hfff0_0000, 16'd4), 1);
    // random: one load in four, else steps, mostly on a small set of entities
    while (sent < 450) begin
      logic [7:0] ent;
      ent = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0)
        send(load_item(ent, pick_word(), pick_word(),
                       ($urandom_range(0, 1) ? 32'($urandom_range(0, 5000)) : pick_word()),
                       pick_word(), pick_word(), pick_word()), sent < 380);
      else
        send(step_item(ent, pick_word(), pick_word(), pick_word(), pick_weight()),
             sent < 380);
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d ground clamps, %0d zero weights",
             sent, result_count, grounded_count, zero_weight_count);
    if (fail_count == 0)
      $display("entity_motion_integrator_core: match");
    else
      $display("entity_motion_integrator_core: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("entity_motion_integrator_core: mismatch");
    $finish;
  end
endmodule
